FILE: rtl/bulk_ring_fifo_defines.svh
// Assertion macros for the bulk ring FIFO.
// Included by modules that carry concurrent checks; expects clk and rst_n in scope.
`ifndef BULK_RING_FIFO_DEFINES_SVH
`define BULK_RING_FIFO_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on the rising clock, off while in reset.
`define BRF_ASSERT_COMB(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bulk_ring_fifo: same-cycle check failed");
// Next-cycle implication, sampled on the rising clock, off while in reset.
`define BRF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bulk_ring_fifo: next-cycle check failed");
`else
`define BRF_ASSERT_COMB(label, ante, cons)
`define BRF_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: rtl/brf_pkg.sv
// Shared constants, codes and types of the bulk ring FIFO.
// Used by brf_ctrl, brf_obuf and bulk_ring_fifo; no dependencies.
package brf_pkg;

  localparam int DEPTH      = 1024;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int PTR_W      = IDX_W + 1;
  localparam int DATA_W     = 32;
  localparam int MAX_BURST  = 64;
  localparam int CNT_W      = 7;
  localparam int OCC_W      = PTR_W;
  localparam int OBUF_DEPTH = 4;
  localparam int OBUF_IDX_W = $clog2(OBUF_DEPTH);
  localparam int OBUF_LVL_W = OBUF_IDX_W + 1;

  typedef enum logic [1:0] {
    KIND_PUSH = 2'd0,
    KIND_POP  = 2'd1,
    KIND_PEEK = 2'd2
  } kind_t;

  typedef enum logic {
    ST_IDLE,
    ST_STREAM
  } state_t;

  typedef struct packed {
    logic             ok;
    logic             has_data;
    logic             last;
    logic [OCC_W-1:0] occupancy;
  } res_meta_t;

  typedef struct packed {
    logic      vld;
    logic      from_ram;
    res_meta_t meta;
  } res_req_t;

  typedef struct packed {
    res_meta_t         meta;
    logic [DATA_W-1:0] data;
  } obuf_ent_t;

endpackage

FILE: rtl/brf_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Standalone; no package dependencies.
module brf_ram #(
  parameter int ADDR_W = 10,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/brf_obuf.sv
// Four-entry result queue that decouples the FIFO core from the result channel.
// Depends on brf_pkg for the result types and queue sizing.
module brf_obuf (
  input  logic                          clk,
  input  logic                          rst_n,
  input  brf_pkg::res_req_t             res_i,
  input  logic [brf_pkg::DATA_W-1:0]    ram_rdata,
  output logic [brf_pkg::OBUF_LVL_W-1:0] level,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_ok,
  output logic                          out_has_data,
  output logic [brf_pkg::DATA_W-1:0]    out_data_res,
  output logic                          out_last_res,
  output logic [brf_pkg::OCC_W-1:0]     out_occupancy
);

  brf_pkg::obuf_ent_t                ent_r [brf_pkg::OBUF_DEPTH];
  brf_pkg::obuf_ent_t                ent_in;
  brf_pkg::obuf_ent_t                ent_out;
  logic [brf_pkg::OBUF_IDX_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [brf_pkg::OBUF_IDX_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [brf_pkg::OBUF_LVL_W-1:0]    level_r, level_nxt;
  logic                              push, pop;

  assign push = res_i.vld;
  assign pop  = out_valid && out_ready;

  // Only beats that carry an element take the memory read data.
  always_comb begin
    ent_in.meta = res_i.meta;
    ent_in.data = res_i.from_ram ? ram_rdata : '0;
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    level_nxt  = level_r + brf_pkg::OBUF_LVL_W'(push) - brf_pkg::OBUF_LVL_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= ent_in;
    end
  end

  assign ent_out       = ent_r[rd_ptr_r];
  assign level         = level_r;
  assign out_valid     = (level_r != '0);
  assign out_ok        = ent_out.meta.ok;
  assign out_has_data  = ent_out.meta.has_data;
  assign out_data_res  = ent_out.data;
  assign out_last_res  = ent_out.meta.last;
  assign out_occupancy = ent_out.meta.occupancy;

endmodule

FILE: rtl/brf_ctrl.sv
// Pointer keeping, burst commit and pop/peek read sequencer of the bulk ring FIFO.
// Depends on brf_pkg; drives the element RAM and feeds brf_obuf.
module brf_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_kind,
  input  logic [brf_pkg::DATA_W-1:0]      in_data,
  input  logic [brf_pkg::CNT_W-1:0]       in_count,
  input  logic                            in_last,
  input  logic [brf_pkg::OBUF_LVL_W-1:0]  obuf_level,
  output logic                            ram_we,
  output logic [brf_pkg::IDX_W-1:0]       ram_waddr,
  output logic [brf_pkg::DATA_W-1:0]      ram_wdata,
  output logic                            ram_re,
  output logic [brf_pkg::IDX_W-1:0]       ram_raddr,
  output brf_pkg::res_req_t               res_o
);

  brf_pkg::state_t                 state_r, state_nxt;
  logic [brf_pkg::PTR_W-1:0]       head_r, head_nxt;
  logic [brf_pkg::PTR_W-1:0]       tail_r, tail_nxt;
  logic [brf_pkg::PTR_W-1:0]       pend_r, pend_nxt;
  logic                            ovf_r, ovf_nxt;
  logic [brf_pkg::PTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [brf_pkg::CNT_W-1:0]       rem_r, rem_nxt;
  logic [brf_pkg::OCC_W-1:0]       occ_r, occ_nxt;
  brf_pkg::res_req_t               res_r, res_nxt;

  logic [brf_pkg::OBUF_LVL_W:0]    inflight;
  logic                            credit_ok;
  logic                            strm_issue;
  logic                            acc;
  logic                            is_req;
  logic                            start_strm;
  logic [brf_pkg::PTR_W-1:0]       fill;
  logic [brf_pkg::PTR_W:0]         used;
  logic                            room;
  logic [brf_pkg::PTR_W-1:0]       cnt_ext;
  logic                            req_ok;
  logic [brf_pkg::PTR_W-1:0]       pend_upd;
  logic                            ovf_upd;

  // A result needs a free queue slot, counting the one already on its way.
  assign inflight  = {1'b0, obuf_level} + (brf_pkg::OBUF_LVL_W + 1)'(res_r.vld);
  assign credit_ok = inflight < (brf_pkg::OBUF_LVL_W + 1)'(brf_pkg::OBUF_DEPTH);

  assign fill    = tail_r - head_r;
  assign used    = {1'b0, fill} + {1'b0, pend_r};
  assign room    = !ovf_r && (used < (brf_pkg::PTR_W + 1)'(brf_pkg::DEPTH));
  assign cnt_ext = brf_pkg::PTR_W'(in_count);
  assign req_ok  = (in_count <= brf_pkg::CNT_W'(brf_pkg::MAX_BURST)) && (cnt_ext <= fill);

  assign acc        = in_valid && in_ready;
  assign is_req     = (in_kind == brf_pkg::KIND_POP) || (in_kind == brf_pkg::KIND_PEEK);
  assign start_strm = acc && is_req && (in_count != '0) && req_ok;

  // State machine outputs.
  always_comb begin
    unique case (state_r)
      brf_pkg::ST_IDLE: begin
        in_ready   = credit_ok;
        strm_issue = 1'b0;
      end
      brf_pkg::ST_STREAM: begin
        in_ready   = 1'b0;
        strm_issue = credit_ok;
      end
      default: begin
        in_ready   = 1'b0;
        strm_issue = 1'b0;
      end
    endcase
  end

  // State machine next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      brf_pkg::ST_IDLE: begin
        if (start_strm) begin
          state_nxt = brf_pkg::ST_STREAM;
        end
      end
      brf_pkg::ST_STREAM: begin
        if (strm_issue && (rem_r == brf_pkg::CNT_W'(1))) begin
          state_nxt = brf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = brf_pkg::ST_IDLE;
    endcase
  end

  // Pointer updates, memory accesses and result generation.
  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    pend_nxt   = pend_r;
    ovf_nxt    = ovf_r;
    rd_ptr_nxt = rd_ptr_r;
    rem_nxt    = rem_r;
    occ_nxt    = occ_r;
    res_nxt    = '0;
    pend_upd   = pend_r;
    ovf_upd    = ovf_r;
    ram_we     = 1'b0;
    ram_waddr  = brf_pkg::IDX_W'(tail_r + pend_r);
    ram_wdata  = in_data;
    ram_re     = strm_issue;
    ram_raddr  = rd_ptr_r[brf_pkg::IDX_W-1:0];

    if (acc) begin
      unique case (in_kind)
        brf_pkg::KIND_PUSH: begin
          if (room) begin
            ram_we   = 1'b1;
            pend_upd = pend_r + 1'b1;
          end else begin
            ovf_upd = 1'b1;
          end
          if (in_last) begin
            res_nxt.vld       = 1'b1;
            res_nxt.meta.ok   = !ovf_upd;
            res_nxt.meta.last = 1'b1;
            if (!ovf_upd) begin
              tail_nxt               = tail_r + pend_upd;
              res_nxt.meta.occupancy = fill + pend_upd;
            end else begin
              res_nxt.meta.occupancy = fill;
            end
            pend_nxt = '0;
            ovf_nxt  = 1'b0;
          end else begin
            pend_nxt = pend_upd;
            ovf_nxt  = ovf_upd;
          end
        end
        brf_pkg::KIND_POP, brf_pkg::KIND_PEEK: begin
          if (in_count == '0) begin
            res_nxt.vld            = 1'b1;
            res_nxt.meta.ok        = 1'b1;
            res_nxt.meta.last      = 1'b1;
            res_nxt.meta.occupancy = fill;
          end else if (!req_ok) begin
            res_nxt.vld            = 1'b1;
            res_nxt.meta.last      = 1'b1;
            res_nxt.meta.occupancy = fill;
          end else begin
            rd_ptr_nxt = head_r;
            rem_nxt    = in_count;
            if (in_kind == brf_pkg::KIND_POP) begin
              head_nxt = head_r + cnt_ext;
              occ_nxt  = fill - cnt_ext;
            end else begin
              occ_nxt = fill;
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (strm_issue) begin
      res_nxt.vld            = 1'b1;
      res_nxt.from_ram       = 1'b1;
      res_nxt.meta.ok        = 1'b1;
      res_nxt.meta.has_data  = 1'b1;
      res_nxt.meta.last      = (rem_r == brf_pkg::CNT_W'(1));
      res_nxt.meta.occupancy = occ_r;
      rd_ptr_nxt             = rd_ptr_r + 1'b1;
      rem_nxt                = rem_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= brf_pkg::ST_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      pend_r  <= '0;
      ovf_r   <= 1'b0;
      res_r   <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      pend_r  <= pend_nxt;
      ovf_r   <= ovf_nxt;
      res_r   <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr_r <= rd_ptr_nxt;
    rem_r    <= rem_nxt;
    occ_r    <= occ_nxt;
  end

  assign res_o = res_r;

endmodule

FILE: rtl/bulk_ring_fifo.sv
// Top level of the bulk ring FIFO: control, element RAM and result queue.
// Depends on brf_pkg, brf_ctrl, brf_ram, brf_obuf and bulk_ring_fifo_defines.svh.
//
// Usage. The input channel (in_*) takes one beat per push element, pop request or
// peek request. Push elements are written straight into the element RAM, one per
// cycle while in_ready is high, and the beat marked in_last commits or rejects
// the whole burst; only that beat returns a result. A pop or peek request returns
// count data beats, the final one flagged by out_last_res, or a single status beat
// when the count is zero or cannot be served. Every result beat carries the
// committed occupancy. A burst status passes through the result register and then
// the result queue; data beats of a pop or peek take the same path once streaming.
// Throughput: push elements go at one per cycle while in_ready is high. A served
// pop or peek holds the input channel after its own beat while the read sequencer
// steps through the RAM read port, one element a cycle while the queue has room.
// Results pass through a four-entry queue; when the receiver stalls, the queue
// fills, reads pause and in_ready falls, and nothing is lost. Reset clears the
// head and tail pointers, the open burst and the queue; the RAM contents are not
// cleared and no clearing pass runs, since only written entries are ever read.
`include "bulk_ring_fifo_defines.svh"

module bulk_ring_fifo (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_kind,
  input  logic [brf_pkg::DATA_W-1:0]   in_data,
  input  logic [brf_pkg::CNT_W-1:0]    in_count,
  input  logic                         in_last,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_ok,
  output logic                         out_has_data,
  output logic [brf_pkg::DATA_W-1:0]   out_data_res,
  output logic                         out_last_res,
  output logic [brf_pkg::OCC_W-1:0]    out_occupancy
);

  logic                              ram_we;
  logic [brf_pkg::IDX_W-1:0]         ram_waddr;
  logic [brf_pkg::DATA_W-1:0]        ram_wdata;
  logic                              ram_re;
  logic [brf_pkg::IDX_W-1:0]         ram_raddr;
  logic [brf_pkg::DATA_W-1:0]        ram_rdata;
  logic [brf_pkg::OBUF_LVL_W-1:0]    obuf_level;
  brf_pkg::res_req_t                 res;

  // Pointers, burst bookkeeping and the read sequencer.
  brf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_kind    (in_kind),
    .in_data    (in_data),
    .in_count   (in_count),
    .in_last    (in_last),
    .obuf_level (obuf_level),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .res_o      (res)
  );

  // Element storage; read data lines up with the registered result descriptor.
  brf_ram #(
    .ADDR_W (brf_pkg::IDX_W),
    .DATA_W (brf_pkg::DATA_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Result queue in front of the output channel.
  brf_obuf u_obuf (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_i         (res),
    .ram_rdata     (ram_rdata),
    .level         (obuf_level),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_ok        (out_ok),
    .out_has_data  (out_has_data),
    .out_data_res  (out_data_res),
    .out_last_res  (out_last_res),
    .out_occupancy (out_occupancy)
  );

  // The credit scheme must keep a result from ever landing in a full queue.
  `BRF_ASSERT_COMB(a_no_push_when_full, res.vld, obuf_level != brf_pkg::OBUF_LVL_W'(brf_pkg::OBUF_DEPTH))
  // The read sequencer and the input channel never run in the same cycle.
  `BRF_ASSERT_COMB(a_read_excl_accept, ram_re, !(in_valid && in_ready))
  // The last element of a burst produces its status beat in the following cycle.
  `BRF_ASSERT_NEXT(a_burst_status, in_valid && in_ready && in_last && in_kind == brf_pkg::KIND_PUSH, res.vld && !res.meta.has_data)

endmodule
